// ===== hw/rtl/sb2a_pkg.sv =====
package sb2a_pkg;

    localparam int VALUE_W        = 32;
    // Ten decimal positions cover every 32-bit magnitude.
    localparam int DIGITS         = 10;
    localparam int DIGIT_W        = 4;
    localparam int NCELLS         = DIGITS * DIGIT_W;
    localparam int STEP_W         = VALUE_W + 2;
    localparam int POS_W          = $clog2(DIGITS);
    localparam int CHAR_W         = 7;
    localparam int MAX_DIGITS_DEF = 10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] rem;
        digit_vec_t         digs;
    } stage_t;

    // Weight of one quotient bit: 10^digit * 2^bit_idx, evaluated at elaboration.
    function automatic logic [STEP_W-1:0] step_value(input int digit, input int bit_idx);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < digit; i++)
        begin
            p = p * 64'd10;
        end
        p = p << bit_idx;
        return p[STEP_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/sb2a_ifs.sv =====
interface sb2a_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sb2a_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sb2a_out_if;
    logic                        valid;
    logic                        ready;
    logic [sb2a_pkg::CHAR_W-1:0] text_char;
    logic                        last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== hw/rtl/signed_binary_to_ascii_decimal.sv =====
// Signed binary to ASCII decimal converter.
//
// The num channel takes one signed 32-bit integer per request. The text
// channel returns its decimal text one ASCII character per request: a '-'
// first for a negative value, then the digits from most to least significant
// with leading zeros suppressed, and last_char set on the final digit. Zero
// prints as a single '0'. Only the low MAX_DIGITS decimal digits are kept.
//
// An integer goes through an entry register and a row of 40 cells, four per
// decimal digit, each cell doing one restoring subtract of a fixed weight.
// The row accepts a new integer every cycle while nothing downstream stalls;
// the sustained rate is set by the character output, one character per cycle
// while the receiver is ready, and a number takes 1 to 11 characters.
//
// Reset clears the entry, row and output valid flags and the output sign and
// position. On a receiver stall the current character holds, the row fills
// up behind it, and num.ready drops once the entry and every cell are full.
module signed_binary_to_ascii_decimal #(
    parameter int MAX_DIGITS = sb2a_pkg::MAX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sb2a_in_if.sink     num,
    sb2a_out_if.source  text
);

    localparam int NCELLS = sb2a_pkg::NCELLS;

    logic                           entry_valid_reg;
    sb2a_pkg::stage_t               entry_data_reg;
    sb2a_pkg::stage_t               entry_data_next;
    logic [sb2a_pkg::VALUE_W-1:0]   raw;

    logic                           valid_c [NCELLS+1];
    logic                           ready_c [NCELLS+1];
    sb2a_pkg::stage_t               data_c  [NCELLS+1];

    assign raw      = num.value;
    assign num.ready = !entry_valid_reg || ready_c[0];

    // The most negative value negates to its own bit pattern, which is the
    // correct unsigned magnitude.
    always_comb
    begin
        entry_data_next.neg  = raw[sb2a_pkg::VALUE_W-1];
        entry_data_next.rem  = raw[sb2a_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
        entry_data_next.digs = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (num.ready)
        begin
            entry_valid_reg <= num.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (num.ready && num.valid)
        begin
            entry_data_reg <= entry_data_next;
        end
    end

    assign valid_c[0] = entry_valid_reg;
    assign data_c[0]  = entry_data_reg;

    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        localparam int DIG = sb2a_pkg::DIGITS - 1 - g / sb2a_pkg::DIGIT_W;
        localparam int BT  = sb2a_pkg::DIGIT_W - 1 - g % sb2a_pkg::DIGIT_W;

        sb2a_cell #(
            .DIGIT_IDX (DIG),
            .BIT_IDX   (BT)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[g]),
            .in_ready  (ready_c[g]),
            .in_data   (data_c[g]),
            .out_valid (valid_c[g+1]),
            .out_ready (ready_c[g+1]),
            .out_data  (data_c[g+1])
        );
    end

    sb2a_emitter #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_c[NCELLS]),
        .in_ready (ready_c[NCELLS]),
        .in_data  (data_c[NCELLS]),
        .text     (text)
    );

endmodule

// ===== hw/rtl/sb2a_cell.sv =====
module sb2a_cell #(
    parameter int DIGIT_IDX = 0,
    parameter int BIT_IDX   = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sb2a_pkg::stage_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sb2a_pkg::stage_t out_data
);

    localparam logic [sb2a_pkg::STEP_W-1:0] STEP = sb2a_pkg::step_value(DIGIT_IDX, BIT_IDX);

    logic                           valid_reg;
    sb2a_pkg::stage_t               data_reg;
    sb2a_pkg::stage_t               data_next;
    logic [sb2a_pkg::STEP_W-1:0]    wide;
    logic [sb2a_pkg::STEP_W-1:0]    diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // One restoring step: take this bit's weight off the remainder if it fits.
    always_comb
    begin
        wide      = {2'b00, in_data.rem};
        diff      = wide - STEP;
        data_next = in_data;
        if (wide >= STEP)
        begin
            data_next.rem                      = diff[sb2a_pkg::VALUE_W-1:0];
            data_next.digs[DIGIT_IDX][BIT_IDX] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/sb2a_emitter.sv =====
module sb2a_emitter #(
    parameter int MAX_DIGITS = sb2a_pkg::MAX_DIGITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sb2a_pkg::stage_t  in_data,
    sb2a_out_if.source        text
);

    logic                           full_reg;
    logic                           sign_reg;
    logic [sb2a_pkg::POS_W-1:0]     pos_reg;
    sb2a_pkg::digit_vec_t           digs_reg;
    logic [sb2a_pkg::POS_W-1:0]     top;
    logic                           out_fire;
    logic                           done;

    // Highest kept nonzero digit; positions at or above MAX_DIGITS are dropped.
    always_comb
    begin
        top = '0;
        for (int i = 0; i < sb2a_pkg::DIGITS; i++)
        begin
            if ((i < MAX_DIGITS) && (in_data.digs[i] != '0))
            begin
                top = sb2a_pkg::POS_W'(i);
            end
        end
    end

    assign out_fire = full_reg && text.ready;
    assign done     = out_fire && !sign_reg && (pos_reg == '0);
    assign in_ready = !full_reg || done;

    assign text.valid     = full_reg;
    assign text.text_char = sign_reg ? sb2a_pkg::CHAR_MINUS
                          : sb2a_pkg::CHAR_ZERO + {3'b000, digs_reg[pos_reg]};
    assign text.last_char = !sign_reg && (pos_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            sign_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (in_ready && in_valid)
        begin
            full_reg <= 1'b1;
            sign_reg <= in_data.neg;
            pos_reg  <= top;
        end
        else if (out_fire)
        begin
            if (sign_reg)
            begin
                sign_reg <= 1'b0;
            end
            else if (pos_reg == '0)
            begin
                full_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            digs_reg <= in_data.digs;
        end
    end

endmodule

// ===== hw/rtl/sb2a_checker.sv =====
module sb2a_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         text_valid,
    input logic                         text_ready,
    input logic [sb2a_pkg::CHAR_W-1:0]  text_char,
    input logic                         last_char
);

    logic fire;
    logic is_minus;
    logic is_digit;

    assign fire     = text_valid && text_ready;
    assign is_minus = (text_char == sb2a_pkg::CHAR_MINUS);
    assign is_digit = (text_char >= sb2a_pkg::CHAR_ZERO)
                   && (text_char <= sb2a_pkg::CHAR_ZERO + 7'd9);

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> (is_minus || is_digit))
        else $error("text character is neither a sign nor a digit");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && is_minus) |-> !last_char)
        else $error("sign flagged as final character");

    a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_minus) |=> (text_valid && is_digit))
        else $error("sign not followed at once by a digit");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && !text_ready) |=>
            (text_valid && $stable(text_char) && $stable(last_char)))
        else $error("stalled character changed");

endmodule

bind signed_binary_to_ascii_decimal sb2a_checker u_sb2a_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .text_char  (text.text_char),
    .last_char  (text.last_char)
);

// ===== verif/tb_signed_binary_to_ascii_decimal.sv =====
`timescale 1ns / 100ps

module tb_signed_binary_to_ascii_decimal;

    localparam int NUM_DIGITS   = sb2a_pkg::MAX_DIGITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    // Idle tail run after the expected text has drained.
    localparam int TAIL_CYCLES  = 80;

    typedef struct {
        logic [sb2a_pkg::CHAR_W-1:0] text_char;
        logic                        last_char;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n;

    sb2a_in_if  num_if ();
    sb2a_out_if text_if ();

    signed_binary_to_ascii_decimal #(
        .MAX_DIGITS (NUM_DIGITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if),
        .text  (text_if)
    );

    text_char_t expected_text_q[$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int error_count   = 0;
    int numbers_sent  = 0;
    int negatives     = 0;
    int chars_checked = 0;
    int cycle_count   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_text_q.size());
            $display("tb_signed_binary_to_ascii_decimal: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        text_if.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Decimal text of one integer, sign first, leading zeros dropped.
    function automatic void predict_text(input logic signed [sb2a_pkg::VALUE_W-1:0] value);
        logic                         neg;
        logic [sb2a_pkg::VALUE_W-1:0] mag;
        logic [3:0]                   digs[NUM_DIGITS];
        int                           top;
        text_char_t                   c;
        neg = value[sb2a_pkg::VALUE_W-1];
        mag = neg ? (32'd0 - value) : value;
        top = 0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digs[i] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            if (digs[i] != 4'd0)
            begin
                top = i;
            end
        end
        if (neg)
        begin
            c.text_char = sb2a_pkg::CHAR_MINUS;
            c.last_char = 1'b0;
            expected_text_q.push_back(c);
        end
        for (int i = top; i >= 0; i--)
        begin
            c.text_char = sb2a_pkg::CHAR_ZERO + sb2a_pkg::CHAR_W'(digs[i]);
            c.last_char = (i == 0);
            expected_text_q.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (rst_n && text_if.valid && text_if.ready)
        begin
            if (expected_text_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %0d last=%0b",
                                          text_if.text_char, text_if.last_char));
            end
            else
            begin
                exp_c = expected_text_q.pop_front();
                chars_checked++;
                if (text_if.text_char !== exp_c.text_char)
                begin
                    report_mismatch($sformatf("text_char %0d, expected %0d",
                                              text_if.text_char, exp_c.text_char));
                end
                if (text_if.last_char !== exp_c.last_char)
                begin
                    report_mismatch($sformatf("last_char %0b, expected %0b on char %0d",
                                              text_if.last_char, exp_c.last_char,
                                              exp_c.text_char));
                end
            end
        end
    end

    task automatic send_number(input logic signed [sb2a_pkg::VALUE_W-1:0] value);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            @(negedge clk);
            num_if.valid <= 1'b0;
        end
        @(negedge clk);
        num_if.valid <= 1'b1;
        num_if.value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!num_if.ready);
        predict_text(value);
        numbers_sent++;
        if (value < 0)
        begin
            negatives++;
        end
    endtask

    task automatic stop_sending();
        @(negedge clk);
        num_if.valid <= 1'b0;
    endtask

    task automatic wait_text_drained();
        while (expected_text_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [sb2a_pkg::VALUE_W-1:0] pick_number();
        longint lo;
        longint hi;
        longint mag;
        int     d;
        logic [15:0] half;
        case ($urandom_range(3, 0))
            0:
            begin
                return $urandom();
            end
            1:
            begin
                // Uniform over the digit count first, so short and long texts are both common.
                d = $urandom_range(10, 1);
                lo = (d == 1) ? 0 : 1;
                hi = 1;
                for (int i = 0; i < d; i++)
                begin
                    hi = hi * 10;
                end
                if (d > 1)
                begin
                    lo = hi / 10;
                end
                hi = hi - 1;
                if (hi > 64'sd2147483647)
                begin
                    hi = 64'sd2147483647;
                end
                mag = lo + longint'($urandom_range(32'(hi - lo), 0));
                return $urandom_range(1, 0) ? sb2a_pkg::VALUE_W'(-mag)
                                            : sb2a_pkg::VALUE_W'(mag);
            end
            2:
            begin
                mag = 1;
                d = $urandom_range(9, 0);
                for (int i = 0; i < d; i++)
                begin
                    mag = mag * 10;
                end
                mag = mag + $urandom_range(2, 0) - 1;
                return $urandom_range(1, 0) ? sb2a_pkg::VALUE_W'(-mag)
                                            : sb2a_pkg::VALUE_W'(mag);
            end
            default:
            begin
                // Sign-extended 16-bit values.
                half = 16'($urandom());
                return {{16{half[15]}}, half};
            end
        endcase
    endfunction

    task automatic test_directed_values();
        logic signed [sb2a_pkg::VALUE_W-1:0] vals[$];
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 32767, -32768,
                 999999999, -999999999, 1000000000, -1000000000, 1000000001,
                 2000000000, 2147483647, -2147483647, 32'sh80000000, 1234567890,
                 -1234567890, 1010101010, 5};
        foreach (vals[i])
        begin
            send_number(vals[i]);
        end
    endtask

    // The sender holds off until the text channel is empty, then restarts.
    task automatic test_drained_restart();
        tx_idle_pct  = 0;
        rx_stall_pct = 40;
        repeat (6)
        begin
            send_number(pick_number());
        end
        stop_sending();
        wait_text_drained();
        repeat (6)
        begin
            send_number(pick_number());
        end
    endtask

    task automatic test_random_numbers(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count)
        begin
            send_number(pick_number());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        num_if.valid  = 1'b0;
        num_if.value  = '0;
        text_if.ready = 1'b0;
        repeat (5)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_values();
        test_drained_restart();
        test_random_numbers(0, 0, 70);
        test_random_numbers(69, 0, 70);
        test_random_numbers(0, 69, 70);
        test_random_numbers(23, 23, 70);
        test_random_numbers(0, 0, 20);

        stop_sending();
        wait_text_drained();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end

        $display("converted %0d integers (%0d negative) and checked %0d characters",
                 numbers_sent, negatives, chars_checked);
        $display("idling phases: none, sender gaps, receiver stalls, both; %0d mismatches",
                 error_count);
        if (error_count == 0)
        begin
            $display("tb_signed_binary_to_ascii_decimal: clean");
        end
        else
        begin
            $display("tb_signed_binary_to_ascii_decimal: errors");
        end
        $finish;
    end

endmodule
